>>> hw/rtl/lttc_pkg.sv
package lttc_pkg;

	// field widths
	localparam int RANGE_W = 16;
	localparam int VEL_W = 16;
	localparam int ANGLE_W = 16;
	localparam int TTC_W = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;

	// scan and sine table geometry
	localparam int MAX_BEAMS = 2048;
	localparam int BEAM_W = $clog2(MAX_BEAMS);
	localparam int SINE_TABLE_ENTRIES = 1024;
	localparam int TAB_W = $clog2(SINE_TABLE_ENTRIES);
	localparam int PHASE_SHIFT = ANGLE_W - TAB_W;
	localparam int QUAD_W = TAB_W - 2;
	localparam int QTAB_DEPTH = (2 ** QUAD_W) + 1;
	localparam int QIDX_W = QUAD_W + 1;
	localparam int MAG_W = 16;
	localparam int SIN_W = MAG_W + 1;

	// closing speed and division
	localparam int V_W = 33;
	localparam int DIV_W = 32;
	localparam int MS_PER_S = 1000;
	localparam int RK_W = 26;
	localparam int FRAC_BITS = 15;
	localparam int QBITS = TTC_W;
	localparam int LOW_SHIFT = QBITS - FRAC_BITS;
	localparam int CNT_W = $clog2(QBITS);

	localparam logic [TTC_W-1:0] TTC_CAP = TTC_W'(100000);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOWER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_UPPER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BRAKE_THR = 3'd4;

	// q28 polynomial constants of the quarter wave
	localparam logic [63:0] K_PI_Q28 = 64'd843314857;
	localparam logic [63:0] K_2PIM5_Q28 = 64'd344452434;
	localparam logic [63:0] K_PIM3_Q28 = 64'd38008489;

	typedef struct packed {
		logic done;
		logic sat;
	} div_stat_t;

	typedef logic [MAG_W-1:0] qtab_t [QTAB_DEPTH];

	function automatic logic [MAG_W-1:0] quarter_sine(input logic [14:0] q);
		logic [63:0] qq;
		logic [63:0] t2;
		logic [63:0] inner;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] r;
		qq = {49'd0, q};
		t2 = qq * qq;
		inner = (K_PIM3_Q28 * t2) >> 28;
		a = K_2PIM5_Q28 - inner;
		b = (a * t2) >> 28;
		c = K_PI_Q28 - b;
		r = (qq * c) >> 28;
		return r[MAG_W-1:0];
	endfunction

	function automatic qtab_t build_qtab();
		qtab_t t;
		for (int j = 0; j < QTAB_DEPTH; j++) begin
			t[j] = quarter_sine(15'(j << PHASE_SHIFT));
		end
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();

endpackage

>>> hw/rtl/lttc_sine_rom.sv
module lttc_sine_rom (
	input  logic                              clk,
	input  logic [lttc_pkg::QIDX_W-1:0]       idx,
	output logic [lttc_pkg::MAG_W-1:0]        mag
);

	logic [lttc_pkg::MAG_W-1:0] mag_q;

	// quarter wave magnitude, registered read
	always_ff @(posedge clk) begin
		mag_q <= lttc_pkg::QTAB[idx];
	end

	assign mag = mag_q;

endmodule

>>> hw/rtl/lttc_div.sv
module lttc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lttc_pkg::RANGE_W-1:0]      range_mm,
	input  logic [lttc_pkg::DIV_W-1:0]        divisor,
	output logic [lttc_pkg::QBITS-1:0]        quotient,
	output lttc_pkg::div_stat_t               stat
);

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_CHECK,
		DV_RUN
	} dv_state_t;

	dv_state_t                        state_q;
	logic [lttc_pkg::DIV_W-1:0]       rem_q;
	logic [lttc_pkg::DIV_W-1:0]       den_q;
	logic [lttc_pkg::QBITS-1:0]       low_q;
	logic [lttc_pkg::QBITS-1:0]       quo_q;
	logic [lttc_pkg::CNT_W-1:0]       cnt_q;
	lttc_pkg::div_stat_t              stat_q;

	logic [lttc_pkg::RK_W-1:0]        rk;
	logic [lttc_pkg::DIV_W:0]         trial;
	logic [lttc_pkg::DIV_W:0]         diff;
	logic                             fits;

	// numerator is range * 1000 * 2^15; its top part must stay below the divisor
	assign rk = lttc_pkg::RK_W'(range_mm * lttc_pkg::RK_W'(lttc_pkg::MS_PER_S));
	assign trial = {rem_q, low_q[lttc_pkg::QBITS-1]};
	assign diff = trial - {1'b0, den_q};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			stat_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				DV_IDLE: begin
					stat_q.done <= 1'b0;
					if (start) begin
						state_q <= DV_CHECK;
					end
				end
				DV_CHECK: begin
					cnt_q <= '0;
					if (rem_q >= den_q) begin
						stat_q.sat <= 1'b1;
						stat_q.done <= 1'b1;
						state_q <= DV_IDLE;
					end else begin
						stat_q.sat <= 1'b0;
						stat_q.done <= 1'b0;
						state_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == lttc_pkg::CNT_W'(lttc_pkg::QBITS - 1)) begin
						stat_q.done <= 1'b1;
						state_q <= DV_IDLE;
					end else begin
						stat_q.done <= 1'b0;
					end
				end
				default: begin
					stat_q.done <= 1'b0;
					state_q <= DV_IDLE;
				end
			endcase
		end
	end

	// datapath: one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			rem_q <= lttc_pkg::DIV_W'(rk[lttc_pkg::RK_W-1:lttc_pkg::LOW_SHIFT]);
			low_q <= {rk[lttc_pkg::LOW_SHIFT-1:0], lttc_pkg::FRAC_BITS'(0)};
			den_q <= divisor;
			quo_q <= '0;
		end else if (state_q == DV_RUN) begin
			rem_q <= fits ? diff[lttc_pkg::DIV_W-1:0] : trial[lttc_pkg::DIV_W-1:0];
			low_q <= {low_q[lttc_pkg::QBITS-2:0], 1'b0};
			quo_q <= {quo_q[lttc_pkg::QBITS-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign stat = stat_q;

endmodule

>>> hw/rtl/lidar_time_to_collision_brake_core.sv
// an odometry update keeps s_tready high; a rejected range sample goes through DONE alone
// an accepted range sample passes the angle, two sine reads and two multiplies,
// then the 17-step bit-serial divider if its closing speed is positive, then DONE
// a scan result is registered when DONE of a last sample finds the output free, once
// odometry has arrived; asynchronous reset sets control registers to their defaults,
// the running minimum to 100000 ms, the scan to beam zero; no clearing pass is needed
module lidar_time_to_collision_brake_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// range_mm[15:0], range_valid[16], vel_x[32:17], vel_y[48:33], zero fill
	input  logic [55:0]                           s_tdata,
	// mode[0]
	input  logic                                  s_tuser,
	input  logic                                  s_tlast,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// min_ttc_ms[16:0], brake[17], zero fill
	output logic [23:0]                           m_tdata,
	input  logic                                  cfg_we,
	input  logic [lttc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lttc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_RSIN,
		ST_RCOS,
		ST_CCOS,
		ST_MUL1,
		ST_MUL2,
		ST_VCHK,
		ST_DIV,
		ST_DONE
	} state_t;

	// configuration
	logic [lttc_pkg::RANGE_W-1:0]         lower_q;
	logic [lttc_pkg::RANGE_W-1:0]         upper_q;
	logic [lttc_pkg::ANGLE_W-1:0]         start_q;
	logic [lttc_pkg::ANGLE_W-1:0]         step_q;
	logic [lttc_pkg::TTC_W-1:0]           thr_q;

	// scan state
	state_t                               state_q;
	logic                                 odom_q;
	logic signed [lttc_pkg::VEL_W-1:0]    vel_x_q;
	logic signed [lttc_pkg::VEL_W-1:0]    vel_y_q;
	logic [lttc_pkg::BEAM_W-1:0]          beam_q;
	logic [lttc_pkg::TTC_W-1:0]           min_q;
	logic                                 m_tvalid_q;
	logic [23:0]                          m_tdata_q;

	// per-sample datapath
	logic [lttc_pkg::RANGE_W-1:0]         range_q;
	logic                                 last_q;
	logic [lttc_pkg::ANGLE_W-1:0]         ang_q;
	logic                                 sin_neg_q;
	logic                                 cos_neg_q;
	logic signed [lttc_pkg::SIN_W-1:0]    sin_q;
	logic signed [lttc_pkg::SIN_W-1:0]    cos_q;
	logic signed [lttc_pkg::V_W-1:0]      prod_q;
	logic signed [lttc_pkg::V_W-1:0]      v_q;

	logic                                 s_xfer;
	logic [lttc_pkg::RANGE_W-1:0]         in_range;
	logic                                 in_valid;
	logic                                 elig;
	logic [lttc_pkg::BEAM_W+lttc_pkg::ANGLE_W-1:0] ang_prod;
	logic [lttc_pkg::TAB_W-1:0]           k_sin;
	logic [lttc_pkg::TAB_W-1:0]           k_cos;
	logic [lttc_pkg::QIDX_W-1:0]          rom_idx;
	logic [lttc_pkg::MAG_W-1:0]           rom_mag;
	logic signed [lttc_pkg::SIN_W-1:0]    rom_signed;
	logic                                 v_pos;
	logic                                 div_start;
	logic [lttc_pkg::QBITS-1:0]           div_quo;
	lttc_pkg::div_stat_t                  div_stat;
	logic [lttc_pkg::TTC_W-1:0]           ttc;
	logic                                 out_free;
	logic                                 res_load;

	function automatic logic [lttc_pkg::QIDX_W-1:0] quarter_index(
		input logic [lttc_pkg::TAB_W-1:0] k
	);
		logic [lttc_pkg::QIDX_W-1:0] j;
		j = {1'b0, k[lttc_pkg::QUAD_W-1:0]};
		// odd quadrants run the quarter wave backwards
		if (k[lttc_pkg::QUAD_W]) begin
			return lttc_pkg::QIDX_W'(lttc_pkg::QTAB_DEPTH - 1) - j;
		end
		return j;
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer = s_tvalid && s_tready;
	assign in_range = s_tdata[15:0];
	assign in_valid = s_tdata[16];
	assign elig = odom_q && in_valid && (in_range >= lower_q) && (in_range <= upper_q)
		&& (in_range != '0);

	assign ang_prod = beam_q * step_q;
	assign k_sin = ang_q[lttc_pkg::ANGLE_W-1:lttc_pkg::PHASE_SHIFT];
	assign k_cos = k_sin + lttc_pkg::TAB_W'(2 ** lttc_pkg::QUAD_W);
	assign rom_idx = (state_q == ST_RSIN) ? quarter_index(k_sin) : quarter_index(k_cos);
	assign rom_signed = $signed({1'b0, rom_mag});

	assign v_pos = !v_q[lttc_pkg::V_W-1] && (v_q != '0);
	assign div_start = (state_q == ST_VCHK) && v_pos;
	assign ttc = (div_stat.sat || (div_quo > lttc_pkg::TTC_CAP)) ? lttc_pkg::TTC_CAP : div_quo;
	assign out_free = !m_tvalid_q || m_tready;
	// the scan result is loaded when a last sample ends with the output free and odometry seen
	assign res_load = (state_q == ST_DONE) && last_q && odom_q && out_free;

	lttc_sine_rom u_rom (
		.clk (clk),
		.idx (rom_idx),
		.mag (rom_mag)
	);

	lttc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.range_mm (range_q),
		.divisor  (v_q[lttc_pkg::DIV_W-1:0]),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= 16'd30000;
			start_q <= 16'hA000;
			step_q <= 16'd60;
			thr_q <= 17'd1500;
		end else if (cfg_we) begin
			case (cfg_index)
				lttc_pkg::REG_RANGE_LOWER: lower_q <= cfg_wdata[lttc_pkg::RANGE_W-1:0];
				lttc_pkg::REG_RANGE_UPPER: upper_q <= cfg_wdata[lttc_pkg::RANGE_W-1:0];
				lttc_pkg::REG_ANGLE_START: start_q <= cfg_wdata[lttc_pkg::ANGLE_W-1:0];
				lttc_pkg::REG_ANGLE_STEP: step_q <= cfg_wdata[lttc_pkg::ANGLE_W-1:0];
				lttc_pkg::REG_BRAKE_THR: thr_q <= cfg_wdata[lttc_pkg::TTC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			odom_q <= 1'b0;
			vel_x_q <= '0;
			vel_y_q <= '0;
			beam_q <= '0;
			min_q <= lttc_pkg::TTC_CAP;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
		end else begin
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						if (!s_tuser) begin
							vel_x_q <= $signed(s_tdata[32:17]);
							vel_y_q <= $signed(s_tdata[48:33]);
							odom_q <= 1'b1;
						end else begin
							state_q <= elig ? ST_ANGLE : ST_DONE;
						end
					end
				end
				ST_ANGLE: state_q <= ST_RSIN;
				ST_RSIN: state_q <= ST_RCOS;
				ST_RCOS: state_q <= ST_CCOS;
				ST_CCOS: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_VCHK;
				ST_VCHK: state_q <= v_pos ? ST_DIV : ST_DONE;
				ST_DIV: begin
					if (div_stat.done) begin
						if (ttc < min_q) begin
							min_q <= ttc;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!last_q) begin
						beam_q <= beam_q + 1'b1;
						state_q <= ST_IDLE;
					end else if (!odom_q) begin
						beam_q <= '0;
						min_q <= lttc_pkg::TTC_CAP;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						m_tdata_q <= {6'd0, (min_q < thr_q), min_q};
						beam_q <= '0;
						min_q <= lttc_pkg::TTC_CAP;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample payload and arithmetic stages
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			range_q <= in_range;
			last_q <= s_tlast;
		end
		case (state_q)
			ST_ANGLE: ang_q <= start_q + ang_prod[lttc_pkg::ANGLE_W-1:0];
			ST_RSIN: sin_neg_q <= k_sin[lttc_pkg::TAB_W-1];
			ST_RCOS: begin
				cos_neg_q <= k_cos[lttc_pkg::TAB_W-1];
				sin_q <= sin_neg_q ? -rom_signed : rom_signed;
			end
			ST_CCOS: cos_q <= cos_neg_q ? -rom_signed : rom_signed;
			ST_MUL1: prod_q <= cos_q * vel_x_q;
			ST_MUL2: v_q <= prod_q + sin_q * vel_y_q;
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

`ifndef NO_ASSERTIONS
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE) && $past(last_q) && $past(odom_q))
		else $error("result raised outside the end of a scan");

	a_min_capped: assert property (@(posedge clk) disable iff (!arst_n)
		min_q <= lttc_pkg::TTC_CAP)
		else $error("running minimum above the cap");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished while not awaited");

	a_scan_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && last_q && (!odom_q || out_free)) |=>
			(beam_q == '0 && min_q == lttc_pkg::TTC_CAP))
		else $error("scan did not restart after its last sample");
`endif

endmodule
